### rtl/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and command codes for the key/value table.
// ----------------------------------------------------------------------------
package kvt_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CMD_W = 2;

	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	typedef struct packed {
		logic                    valid;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} kvt_entry_t;

	typedef struct packed {
		logic cmp_en;
		logic append;
		logic wr_val;
		logic shift;
	} kvt_ctrl_t;

endpackage

### rtl/kvt_cell.sv
// ----------------------------------------------------------------------------
// kvt_cell
// One table slot: holds a key, a value and a valid flag, compares its key
// against the search key and takes its neighbor's entry when slots close up.
// ----------------------------------------------------------------------------
module kvt_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  kvt_pkg::kvt_ctrl_t              ctrl,
	input  logic signed [kvt_pkg::KEY_W-1:0] cmp_key,
	input  logic signed [kvt_pkg::KEY_W-1:0] new_key,
	input  logic signed [kvt_pkg::VAL_W-1:0] new_value,
	input  logic                            prev_valid,
	input  kvt_pkg::kvt_entry_t             nbr,
	output kvt_pkg::kvt_entry_t             entry,
	output logic                            match
);
	import kvt_pkg::*;

	logic                    valid_q;
	logic                    match_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [VAL_W-1:0] value_q;
	logic                    load_new;

	// first empty slot takes an appended entry
	assign load_new = ctrl.append & ~valid_q & prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctrl.shift) begin
				valid_q <= nbr.valid;
			end else if (load_new) begin
				valid_q <= 1'b1;
			end
			if (ctrl.cmp_en) begin
				match_q <= valid_q & (key_q == cmp_key);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			key_q   <= nbr.key;
			value_q <= nbr.value;
		end else if (load_new) begin
			key_q   <= new_key;
			value_q <= new_value;
		end else if (ctrl.wr_val) begin
			value_q <= new_value;
		end
	end

	assign entry = '{valid: valid_q, key: key_q, value: value_q};
	assign match = match_q;

endmodule

### rtl/key_value_table.sv
// ----------------------------------------------------------------------------
// key_value_table
// Associative table of signed key/value pairs held in a row of slot cells.
// ----------------------------------------------------------------------------
// For every command the key is compared against all slots at the accepting
// edge, and at the following edge the table is updated and the result is
// registered; done is high for the cycle after that and busy is
// high for the one cycle in between. There is no way to stall the result,
// so the receiver must take it in the cycle that done is high. Removal closes
// the gap by shifting the higher slots down one cell.
module key_value_table #(
	parameter int DEPTH = 16,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [kvt_pkg::CMD_W-1:0]       cmd,
	input  logic signed [kvt_pkg::KEY_W-1:0] key,
	input  logic signed [kvt_pkg::VAL_W-1:0] value,
	output logic                            done,
	output logic                            found,
	output logic signed [kvt_pkg::VAL_W-1:0] old_value,
	output logic [CNT_W-1:0]                entry_count,
	output logic                            full_reject
);
	import kvt_pkg::*;

	logic                    pend_q;
	logic [CMD_W-1:0]        cmd_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [VAL_W-1:0] value_q;
	logic                    done_q;
	logic                    found_q;
	logic                    full_rej_q;
	logic signed [VAL_W-1:0] old_q;
	logic [CNT_W-1:0]        count_q;

	kvt_entry_t              ent [DEPTH];
	kvt_ctrl_t               ctrl [DEPTH];
	logic [DEPTH-1:0]        match_v;
	logic [DEPTH-1:0]        ge_v;
	logic signed [VAL_W-1:0] old_or;
	logic                    accept;
	logic                    any;
	logic                    cmd_ok;
	logic                    is_add;
	logic                    is_rem;
	logic                    full;
	logic                    do_append;
	logic                    do_remove;

	assign accept    = start & ~pend_q;
	assign busy      = pend_q;
	assign any       = |match_v;
	assign is_add    = (cmd_q == CMD_ADD);
	assign is_rem    = (cmd_q == CMD_REMOVE);
	assign cmd_ok    = is_add | is_rem | (cmd_q == CMD_SEARCH);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign do_append = pend_q & is_add & ~any & ~full;
	assign do_remove = pend_q & is_rem & any;
	// slots at and above the matching one
	assign ge_v      = ~(match_v - DEPTH'(1));

	always_comb begin
		old_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (match_v[i]) begin
				old_or = old_or | ent[i].value;
			end
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		kvt_entry_t nbr;
		logic       prev_valid;

		if (i == DEPTH - 1) begin : g_end
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = ent[i+1];
		end
		if (i == 0) begin : g_first
			assign prev_valid = 1'b1;
		end else begin : g_rest
			assign prev_valid = ent[i-1].valid;
		end

		assign ctrl[i] = '{cmp_en: accept,
		                   append: do_append,
		                   wr_val: pend_q & is_add & match_v[i],
		                   shift:  do_remove & ge_v[i]};

		kvt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl[i]),
			.cmp_key    (key),
			.new_key    (key_q),
			.new_value  (value_q),
			.prev_valid (prev_valid),
			.nbr        (nbr),
			.entry      (ent[i]),
			.match      (match_v[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= 1'b0;
			done_q     <= 1'b0;
			found_q    <= 1'b0;
			full_rej_q <= 1'b0;
			count_q    <= '0;
		end else begin
			done_q <= pend_q;
			if (accept) begin
				pend_q <= 1'b1;
			end else if (pend_q) begin
				pend_q     <= 1'b0;
				found_q    <= cmd_ok & any;
				full_rej_q <= is_add & ~any & full;
				if (do_append) begin
					count_q <= count_q + CNT_W'(1);
				end else if (do_remove) begin
					count_q <= count_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd;
			key_q   <= key;
			value_q <= value;
		end
		if (pend_q) begin
			old_q <= (cmd_ok & any) ? old_or : '0;
		end
	end

	assign done        = done_q;
	assign found       = found_q;
	assign old_value   = old_q;
	assign entry_count = count_q;
	assign full_reject = full_rej_q;

	a_done_after_busy : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a command in flight");

	a_reject_not_found : assert property (@(posedge clk) disable iff (!arst_n)
		done && full_reject |-> !found && entry_count == CNT_W'(DEPTH))
		else $error("refused add with a hit or a table that is not full");

	a_miss_zero : assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> old_value == '0)
		else $error("miss with a nonzero old value");

	a_count_range : assert property (@(posedge clk) disable iff (!arst_n)
		entry_count <= CNT_W'(DEPTH))
		else $error("entry count beyond table depth");

	a_count_step : assert property (@(posedge clk) disable iff (!arst_n)
		!done |=> $stable(entry_count) || $past(busy))
		else $error("entry count changed outside a command");

endmodule

### tb/key_value_table_tb.sv
// ----------------------------------------------------------------------------
// key_value_table_tb
// Self-checking bench for the key/value table. Commands are sent over the
// start/busy handshake and each accepted transfer is run through a local
// model of the table; every done strobe is checked against the oldest
// predicted answer. Directed cases cover empty and full tables, extreme keys
// and values, updates, misses and the unused command code. A long random run
// then mixes fill and drain phases with idle bursts.
// ----------------------------------------------------------------------------
module key_value_table_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import kvt_pkg::*;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
	localparam logic signed [KEY_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] WORD_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic                    found;
		logic signed [VAL_W-1:0] old_value;
		logic [CNT_W-1:0]        entry_count;
		logic                    full_reject;
	} kvt_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [CMD_W-1:0]        cmd;
	logic signed [KEY_W-1:0] key;
	logic signed [VAL_W-1:0] value;
	logic                    done;
	logic                    found;
	logic signed [VAL_W-1:0] old_value;
	logic [CNT_W-1:0]        entry_count;
	logic                    full_reject;

	logic signed [KEY_W-1:0] table_keys [DEPTH];
	logic signed [VAL_W-1:0] table_vals [DEPTH];
	int                      table_count = 0;
	kvt_result_t             expected_results [$];
	int                      fail_count = 0;
	bit                      idle_enable = 1'b1;

	key_value_table #(
		.DEPTH(DEPTH)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.key        (key),
		.value      (value),
		.done       (done),
		.found      (found),
		.old_value  (old_value),
		.entry_count(entry_count),
		.full_reject(full_reject)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic kvt_result_t lookup_and_update(input logic [CMD_W-1:0] c,
		input logic signed [KEY_W-1:0] k, input logic signed [VAL_W-1:0] v);
		kvt_result_t r;
		int          slot;
		slot = -1;
		r = '0;
		if (c != CMD_NOP) begin
			for (int i = 0; i < table_count; i++) begin
				if (slot < 0 && table_keys[i] == k) begin
					slot = i;
				end
			end
			if (slot >= 0) begin
				r.found = 1'b1;
				r.old_value = table_vals[slot];
			end
			if (c == CMD_ADD) begin
				if (slot >= 0) begin
					table_vals[slot] = v;
				end else if (table_count < DEPTH) begin
					table_keys[table_count] = k;
					table_vals[table_count] = v;
					table_count++;
				end else begin
					r.full_reject = 1'b1;
				end
			end else if (c == CMD_REMOVE && slot >= 0) begin
				table_keys[slot] = table_keys[table_count-1];
				table_vals[slot] = table_vals[table_count-1];
				table_count--;
			end
		end
		r.entry_count = table_count[CNT_W-1:0];
		return r;
	endfunction

	// start stays high across back-to-back transfers, dropped only for gaps
	task automatic send_transfer(input logic [CMD_W-1:0] c,
		input logic signed [KEY_W-1:0] k, input logic signed [VAL_W-1:0] v);
		int gap;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		key <= k;
		value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_results.push_back(lookup_and_update(c, k, v));
	endtask

	always @(posedge clk) begin : check_results
		kvt_result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("unexpected result: found %b old_value %0d count %0d reject %b",
						found, old_value, entry_count, full_reject);
				end
			end else begin
				want = expected_results.pop_front();
				if (found !== want.found || old_value !== want.old_value ||
					entry_count !== want.entry_count || full_reject !== want.full_reject) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("mismatch: found %b/%b old_value %0d/%0d count %0d/%0d reject %b/%b",
							want.found, found, want.old_value, old_value,
							want.entry_count, entry_count, want.full_reject, full_reject);
					end
				end
			end
		end
	end

	task automatic test_basic_ops();
		send_transfer(CMD_SEARCH, 32'sd0, 32'sd0);
		send_transfer(CMD_REMOVE, WORD_MAX, 32'sd0);
		send_transfer(CMD_ADD, WORD_MIN, WORD_MAX);
		send_transfer(CMD_ADD, WORD_MAX, WORD_MIN);
		send_transfer(CMD_ADD, 32'sd0, -32'sd1);
		send_transfer(CMD_ADD, -32'sd1, 32'sd0);
		send_transfer(CMD_SEARCH, WORD_MAX, 32'sd0);
		send_transfer(CMD_ADD, WORD_MIN, 32'sh5a5a_a5a5);
		send_transfer(CMD_SEARCH, 32'sd12345, 32'sd0);
		send_transfer(CMD_REMOVE, 32'sd1, 32'sd0);
		send_transfer(CMD_NOP, WORD_MIN, WORD_MAX);
		// the model refills the freed slot from the end; the table shifts slots down
		send_transfer(CMD_REMOVE, WORD_MIN, 32'sd0);
		send_transfer(CMD_SEARCH, -32'sd1, 32'sd0);
		send_transfer(CMD_REMOVE, -32'sd1, 32'sd0);
		send_transfer(CMD_SEARCH, 32'sd0, 32'sd0);
	endtask

	task automatic test_full_table();
		while (table_count < DEPTH) begin
			send_transfer(CMD_ADD, $urandom, $urandom);
		end
		send_transfer(CMD_ADD, 32'sh1357_2468, 32'sd7);
		send_transfer(CMD_ADD, WORD_MAX, 32'sh0f0f_f0f0);
		send_transfer(CMD_NOP, 32'sd0, 32'sd0);
		send_transfer(CMD_REMOVE, 32'sd0, 32'sd0);
		send_transfer(CMD_ADD, 32'sh2468_1357, -32'sd7);
	endtask

	task automatic test_random_traffic(input int n);
		logic signed [KEY_W-1:0] key_pool [40];
		int                      pool_size;
		bit                      drain;
		int                      pick;
		logic [CMD_W-1:0]        c;
		logic signed [KEY_W-1:0] k;
		pool_size = 1;
		drain = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (i % 200 == 0) begin
				pool_size = $urandom_range(2, 40);
				drain = ($urandom_range(0, 2) == 0);
				for (int j = 0; j < pool_size; j++) begin
					key_pool[j] = $urandom;
				end
				key_pool[0] = WORD_MIN;
				key_pool[1] = WORD_MAX;
			end
			if (i % 100 == 0) begin
				idle_enable = (i < n - 300) && ($urandom_range(0, 2) != 0);
			end
			pick = $urandom_range(0, 99);
			if (drain) begin
				c = (pick < 20) ? CMD_ADD : (pick < 45) ? CMD_SEARCH :
					(pick < 95) ? CMD_REMOVE : CMD_NOP;
			end else begin
				c = (pick < 45) ? CMD_ADD : (pick < 72) ? CMD_SEARCH :
					(pick < 95) ? CMD_REMOVE : CMD_NOP;
			end
			pick = $urandom_range(0, 9);
			if (pick < 3 && table_count > 0) begin
				k = table_keys[$urandom_range(0, table_count - 1)];
			end else if (pick < 9) begin
				k = key_pool[$urandom_range(0, pool_size - 1)];
			end else begin
				k = $urandom;
			end
			send_transfer(c, k, $urandom);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= CMD_ADD;
		key <= '0;
		value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_basic_ops();
		test_full_table();
		test_random_traffic(2000);
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

### key_value_table.f
rtl/kvt_pkg.sv
rtl/kvt_cell.sv
rtl/key_value_table.sv
tb/key_value_table_tb.sv
